[design/upd_pkg.sv]
// Shared types and constants of the ultrasonic presence detector.
// Used by every module of the design but upd_fifo; depends on nothing.
package upd_pkg;

	localparam int SPEED_SHIFT = 13;
	localparam int PRODUCT_W = 32;
	localparam int DIST_FULL_W = PRODUCT_W - SPEED_SHIFT;
	localparam int DIST_W = 15;
	localparam int RUN_W = 8;
	localparam int AGE_W = 24;
	localparam int MS_W = 10;
	localparam int SEC_W = 32;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam int QUEUE_DEPTH = 2;
	localparam int BLINK_HALF_PERIOD_MS_DEF = 300;

	localparam logic [RUN_W-1:0] RUN_CEILING = '1;
	localparam logic [AGE_W-1:0] AGE_CEILING = '1;
	localparam logic [SEC_W-1:0] SEC_CEILING = '1;
	localparam logic [MS_W-1:0] MS_PER_SECOND = 10'd1000;

	localparam logic [1:0] FUNC_ECHO = 2'd0;
	localparam logic [1:0] FUNC_TICK = 2'd1;
	localparam logic [1:0] FUNC_ALERT_SENT = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] REG_SOUND_SPEED = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_DISTANCE = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_DISTANCE = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_DETECT_THRESHOLD = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_HYSTERESIS = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_READINGS_REQUIRED = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_ALERT_INTERVAL = 3'd6;

	localparam logic [15:0] SOUND_SPEED_RST = 16'd2248;
	localparam logic [DIST_W-1:0] MIN_DISTANCE_RST = 15'd32;
	localparam logic [DIST_W-1:0] MAX_DISTANCE_RST = 15'd6400;
	localparam logic [DIST_W-1:0] DETECT_THRESHOLD_RST = 15'd1600;
	localparam logic [DIST_W-1:0] HYSTERESIS_RST = 15'd160;
	localparam logic [RUN_W-1:0] READINGS_REQUIRED_RST = 8'd3;
	localparam logic [AGE_W-1:0] ALERT_INTERVAL_RST = 24'd60000;

	typedef struct packed {
		logic [1:0] func;
		logic [15:0] echo_us;
	} item_t;

	typedef struct packed {
		logic detecting;
		logic reading_valid;
		logic [DIST_W-1:0] object_distance;
		logic alert_due;
		logic led_on;
		logic [SEC_W-1:0] seconds_present;
		logic entered;
		logic left;
	} status_t;

	typedef struct packed {
		logic [15:0] sound_speed_q16;
		logic [DIST_W-1:0] min_distance;
		logic [DIST_W-1:0] max_distance;
		logic [DIST_W-1:0] detect_threshold;
		logic [DIST_W-1:0] hysteresis_margin;
		logic [RUN_W-1:0] readings_required;
		logic [AGE_W-1:0] alert_interval_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0] func;
		logic reading_ok;
		logic [DIST_W-1:0] distance;
	} cmd_t;

endpackage

[design/upd_fifo.sv]
// Small first-in first-out queue of packed words built from registers.
// Generic in word type and depth; no package dependency.
module upd_fifo #(
	parameter type word_t = logic,
	parameter int Depth = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  word_t wdata,
	input  logic  pop,
	output logic  empty,
	output word_t rdata
);
	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

	word_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CntW'(Depth));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/upd_front.sv]
// Front end: takes input words, converts the echo width to a distance and
// classifies it against the window. Depends on upd_pkg.
module upd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  upd_pkg::item_t item,
	input  upd_pkg::cfg_t  cfg,
	output logic           cmd_push,
	input  logic           cmd_full,
	output upd_pkg::cmd_t  cmd
);
	import upd_pkg::*;

	logic valid_s1;
	logic [1:0] func_s1;
	logic echo_nz_s1;
	logic [DIST_FULL_W-1:0] dist_s1;
	logic [PRODUCT_W-1:0] product;
	logic accept;
	logic in_window;

	assign product = PRODUCT_W'(item.echo_us) * PRODUCT_W'(cfg.sound_speed_q16);
	assign full = valid_s1 && cmd_full;
	assign accept = push && !full;
	assign cmd_push = valid_s1 && !cmd_full;

	assign in_window = (dist_s1 >= DIST_FULL_W'(cfg.min_distance))
		&& (dist_s1 <= DIST_FULL_W'(cfg.max_distance));

	always_comb begin
		cmd.func = func_s1;
		cmd.reading_ok = echo_nz_s1 && in_window;
		cmd.distance = dist_s1[DIST_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= item.func;
			echo_nz_s1 <= (item.echo_us != '0);
			dist_s1 <= product[PRODUCT_W-1:SPEED_SHIFT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (cmd_push) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule

[design/upd_back.sv]
// Back end: applies one classified word per cycle, while the status queue has
// room, to the detection state and forms the status word. Depends on upd_pkg.
module upd_back #(
	parameter int BLINK_HALF_PERIOD_MS = upd_pkg::BLINK_HALF_PERIOD_MS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  upd_pkg::cfg_t    cfg,
	input  logic             cmd_empty,
	input  upd_pkg::cmd_t    cmd,
	output logic             cmd_pop,
	input  logic             status_full,
	output logic             status_push,
	output upd_pkg::status_t status
);
	import upd_pkg::*;

	localparam int BlinkW = $clog2(BLINK_HALF_PERIOD_MS + 1);
	localparam logic [BlinkW-1:0] BlinkHalf = BlinkW'(BLINK_HALF_PERIOD_MS);

	logic active_q, active_d;
	logic [RUN_W-1:0] in_run_q, in_run_d;
	logic [RUN_W-1:0] out_run_q, out_run_d;
	logic [DIST_W-1:0] latest_q, latest_d;
	logic [AGE_W-1:0] age_q, age_d;
	logic [BlinkW-1:0] blink_q, blink_d;
	logic lamp_q, lamp_d;
	logic [MS_W-1:0] ms_q, ms_d;
	logic [SEC_W-1:0] sec_q, sec_d;

	logic [DIST_W:0] limit;
	logic near;
	logic [RUN_W-1:0] in_run_inc;
	logic [RUN_W-1:0] out_run_inc;
	logic [BlinkW-1:0] blink_inc;
	logic [MS_W-1:0] ms_inc;
	logic valid_rd;
	logic entered;
	logic left;

	assign cmd_pop = !cmd_empty && !status_full;
	assign status_push = cmd_pop;

	assign limit = {1'b0, cfg.detect_threshold}
		+ (active_q ? {1'b0, cfg.hysteresis_margin} : '0);
	assign near = {1'b0, cmd.distance} <= limit;

	always_comb begin
		active_d = active_q;
		in_run_d = in_run_q;
		out_run_d = out_run_q;
		latest_d = latest_q;
		age_d = age_q;
		blink_d = blink_q;
		lamp_d = lamp_q;
		ms_d = ms_q;
		sec_d = sec_q;
		valid_rd = 1'b0;
		entered = 1'b0;
		left = 1'b0;
		in_run_inc = '0;
		out_run_inc = '0;
		blink_inc = '0;
		ms_inc = '0;

		case (cmd.func)
			FUNC_ECHO: begin
				if (cmd.reading_ok) begin
					valid_rd = 1'b1;
					latest_d = cmd.distance;
					in_run_inc = (in_run_q == RUN_CEILING) ? in_run_q : in_run_q + 1'b1;
					in_run_d = near ? in_run_inc : '0;
					if (!active_q && in_run_d >= cfg.readings_required) begin
						active_d = 1'b1;
						entered = 1'b1;
						in_run_d = '0;
						age_d = AGE_CEILING;
						lamp_d = 1'b1;
						blink_d = '0;
						ms_d = '0;
						sec_d = '0;
					end else if (active_q && !near) begin
						out_run_inc = (out_run_q == RUN_CEILING) ? out_run_q
							: out_run_q + 1'b1;
						out_run_d = out_run_inc;
						if (out_run_inc >= cfg.readings_required) begin
							active_d = 1'b0;
							left = 1'b1;
							out_run_d = '0;
							lamp_d = 1'b0;
							blink_d = '0;
							ms_d = '0;
							sec_d = '0;
						end
					end else begin
						out_run_d = '0;
					end
				end else begin
					in_run_d = '0;
				end
			end
			FUNC_TICK: begin
				if (age_q != AGE_CEILING) begin
					age_d = age_q + 1'b1;
				end
				if (active_q) begin
					blink_inc = blink_q + 1'b1;
					if (blink_inc >= BlinkHalf) begin
						lamp_d = !lamp_q;
						blink_d = '0;
					end else begin
						blink_d = blink_inc;
					end
					ms_inc = ms_q + 1'b1;
					if (ms_inc >= MS_PER_SECOND) begin
						ms_d = '0;
						if (sec_q != SEC_CEILING) begin
							sec_d = sec_q + 1'b1;
						end
					end else begin
						ms_d = ms_inc;
					end
				end
			end
			FUNC_ALERT_SENT: begin
				age_d = '0;
			end
			default: begin
			end
		endcase

		status.detecting = active_d;
		status.reading_valid = valid_rd;
		status.object_distance = active_d ? latest_d : '0;
		status.alert_due = active_d && (age_d >= cfg.alert_interval_ms);
		status.led_on = lamp_d;
		status.seconds_present = active_d ? sec_d : '0;
		status.entered = entered;
		status.left = left;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			in_run_q <= '0;
			out_run_q <= '0;
			latest_q <= '0;
			age_q <= '0;
			blink_q <= '0;
			lamp_q <= 1'b0;
			ms_q <= '0;
			sec_q <= '0;
		end else if (cmd_pop) begin
			active_q <= active_d;
			in_run_q <= in_run_d;
			out_run_q <= out_run_d;
			latest_q <= latest_d;
			age_q <= age_d;
			blink_q <= blink_d;
			lamp_q <= lamp_d;
			ms_q <= ms_d;
			sec_q <= sec_d;
		end
	end

endmodule

[design/ultrasonic_presence_detector_core.sv]
// Top level of the ultrasonic presence detector: configuration registers,
// front end, command queue, back end and status queue. Depends on upd_pkg.
//
// Each input word (an echo width, a millisecond tick or an alert mark)
// yields exactly one status word, in order. The block takes one word per
// clock and returns one status word per clock when both sides keep up;
// a status word passes through the front-end register, the command queue
// and the status queue before it is visible. The back end applies one
// word per cycle to the detection state while the status queue has room;
// the echo multiply sits in its own front-end register stage.
// Configuration is written with cfg_we and takes effect at once.
module ultrasonic_presence_detector_core #(
	parameter int BLINK_HALF_PERIOD_MS = upd_pkg::BLINK_HALF_PERIOD_MS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  upd_pkg::item_t                     item,
	output logic                               empty,
	input  logic                               pop,
	output upd_pkg::status_t                   status,
	input  logic                               cfg_we,
	input  logic [upd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [upd_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import upd_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd_wr;
	cmd_t cmd_rd;
	status_t status_wr;
	logic cmd_push;
	logic cmd_full;
	logic cmd_empty;
	logic cmd_pop;
	logic status_push;
	logic status_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sound_speed_q16 <= SOUND_SPEED_RST;
			cfg_q.min_distance <= MIN_DISTANCE_RST;
			cfg_q.max_distance <= MAX_DISTANCE_RST;
			cfg_q.detect_threshold <= DETECT_THRESHOLD_RST;
			cfg_q.hysteresis_margin <= HYSTERESIS_RST;
			cfg_q.readings_required <= READINGS_REQUIRED_RST;
			cfg_q.alert_interval_ms <= ALERT_INTERVAL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SOUND_SPEED: cfg_q.sound_speed_q16 <= cfg_data[15:0];
				REG_MIN_DISTANCE: cfg_q.min_distance <= cfg_data[DIST_W-1:0];
				REG_MAX_DISTANCE: cfg_q.max_distance <= cfg_data[DIST_W-1:0];
				REG_DETECT_THRESHOLD: cfg_q.detect_threshold <= cfg_data[DIST_W-1:0];
				REG_HYSTERESIS: cfg_q.hysteresis_margin <= cfg_data[DIST_W-1:0];
				REG_READINGS_REQUIRED: cfg_q.readings_required <= cfg_data[RUN_W-1:0];
				REG_ALERT_INTERVAL: cfg_q.alert_interval_ms <= cfg_data[AGE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	upd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.cfg      (cfg_q),
		.cmd_push (cmd_push),
		.cmd_full (cmd_full),
		.cmd      (cmd_wr)
	);

	upd_fifo #(
		.word_t (cmd_t),
		.Depth  (QUEUE_DEPTH)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.full   (cmd_full),
		.wdata  (cmd_wr),
		.pop    (cmd_pop),
		.empty  (cmd_empty),
		.rdata  (cmd_rd)
	);

	upd_back #(
		.BLINK_HALF_PERIOD_MS (BLINK_HALF_PERIOD_MS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd_empty   (cmd_empty),
		.cmd         (cmd_rd),
		.cmd_pop     (cmd_pop),
		.status_full (status_full),
		.status_push (status_push),
		.status      (status_wr)
	);

	upd_fifo #(
		.word_t (status_t),
		.Depth  (QUEUE_DEPTH)
	) u_status_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (status_push),
		.full   (status_full),
		.wdata  (status_wr),
		.pop    (pop),
		.empty  (empty),
		.rdata  (status)
	);

endmodule
